FILE: rtl/core/spimc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master controller package
// Shared types, register indexes and reset values for the SPI master blocks.
// ----------------------------------------------------------------------------
package spimc_pkg;

  localparam int MaxFrameBitsDef = 16;
  localparam int MaxDivCodeDef   = 7;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 8;
  localparam int InTdataW  = 24;
  localparam int OutTdataW = 24;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] RegClockDivCode   = 3'd0;
  localparam logic [CfgIndexW-1:0] RegFrameBits      = 3'd1;
  localparam logic [CfgIndexW-1:0] RegLowBitFirst    = 3'd2;
  localparam logic [CfgIndexW-1:0] RegClockIdleHigh  = 3'd3;
  localparam logic [CfgIndexW-1:0] RegSampleLate     = 3'd4;
  localparam logic [CfgIndexW-1:0] RegGapPulseEnable = 3'd5;

  // Register reset values.
  localparam logic [2:0] ClockDivCodeRst   = 3'd7;
  localparam logic [4:0] FrameBitsRst      = 5'd8;
  localparam logic       LowBitFirstRst    = 1'b0;
  localparam logic       ClockIdleHighRst  = 1'b0;
  localparam logic       SampleLateRst     = 1'b0;
  localparam logic       GapPulseEnableRst = 1'b0;

  typedef struct packed {
    logic [2:0] clock_div_code;
    logic [4:0] frame_bits;
    logic       low_bit_first;
    logic       clock_idle_high;
    logic       sample_late;
    logic       gap_pulse_enable;
  } cfg_t;

  typedef struct packed {
    logic        miso_in;
    logic        cs_level;
    logic        cs_write;
    logic        rx_read;
    logic [15:0] tx_data;
    logic        tx_write;
  } item_t;

  typedef struct packed {
    logic        tx_accepted;
    logic        busy_res;
    logic [15:0] rx_data;
    logic        rx_full;
    logic        tx_empty;
    logic        cs_out;
    logic        mosi_out;
    logic        sclk_out;
  } res_t;

  typedef struct packed {
    logic shifting;
    logic gap_active;
    logic tx_hold_full;
  } eng_status_t;

endpackage

FILE: rtl/core/spimc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master configuration registers
// Decodes register writes and holds the controller settings.
// ----------------------------------------------------------------------------
module spimc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [spimc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [spimc_pkg::CfgDataW-1:0]  cfg_data,
  output spimc_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_div_code   <= spimc_pkg::ClockDivCodeRst;
      cfg.frame_bits       <= spimc_pkg::FrameBitsRst;
      cfg.low_bit_first    <= spimc_pkg::LowBitFirstRst;
      cfg.clock_idle_high  <= spimc_pkg::ClockIdleHighRst;
      cfg.sample_late      <= spimc_pkg::SampleLateRst;
      cfg.gap_pulse_enable <= spimc_pkg::GapPulseEnableRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        spimc_pkg::RegClockDivCode:   cfg.clock_div_code   <= cfg_data[2:0];
        spimc_pkg::RegFrameBits:      cfg.frame_bits       <= cfg_data[4:0];
        spimc_pkg::RegLowBitFirst:    cfg.low_bit_first    <= cfg_data[0];
        spimc_pkg::RegClockIdleHigh:  cfg.clock_idle_high  <= cfg_data[0];
        spimc_pkg::RegSampleLate:     cfg.sample_late      <= cfg_data[0];
        spimc_pkg::RegGapPulseEnable: cfg.gap_pulse_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/spimc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master shift engine
// Buffers, prescaler, shifters and pin state; advances one tick per step.
// ----------------------------------------------------------------------------
module spimc_engine #(
  parameter int MAX_FRAME_BITS = spimc_pkg::MaxFrameBitsDef,
  parameter int MAX_DIV_CODE   = spimc_pkg::MaxDivCodeDef
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  spimc_pkg::cfg_t        cfg,
  input  spimc_pkg::item_t       item,
  output spimc_pkg::res_t        res,
  output spimc_pkg::eng_status_t status
);

  localparam int W       = MAX_FRAME_BITS;
  localparam int BcW     = $clog2(MAX_FRAME_BITS + 1);
  localparam int IdxW    = $clog2(MAX_FRAME_BITS);
  localparam int CodeMax = (MAX_DIV_CODE < 7) ? MAX_DIV_CODE : 7;
  localparam int PsW     = CodeMax + 1;

  logic [PsW-1:0] prescale_count, prescale_count_next;
  logic [BcW-1:0] bit_count, bit_count_next;
  logic [W-1:0]   tx_shift, tx_shift_next;
  logic [W-1:0]   rx_shift, rx_shift_next;
  logic [15:0]    tx_hold, tx_hold_next;
  logic [15:0]    rx_hold, rx_hold_next;
  logic           tx_hold_full, tx_hold_full_next;
  logic           rx_hold_full, rx_hold_full_next;
  logic           clock_level, clock_level_next;
  logic           shifting, shifting_next;
  logic           gap_active, gap_active_next;
  logic           soft_cs, soft_cs_next;

  logic [BcW-1:0] eff_bits;
  logic [2:0]     eff_code;
  logic [PsW:0]   half, full, ps_inc;
  logic [IdxW-1:0] top_idx;
  logic [W-1:0]   frame_mask;
  logic           accepted, leading, head;

  // Effective frame length and divider after clamping.
  always_comb begin
    if ({1'b0, cfg.frame_bits} > 6'(MAX_FRAME_BITS)) begin
      eff_bits = BcW'(MAX_FRAME_BITS);
    end else if (cfg.frame_bits < 5'd4) begin
      eff_bits = BcW'(4);
    end else begin
      eff_bits = BcW'(cfg.frame_bits);
    end
    if ({1'b0, cfg.clock_div_code} > 4'(CodeMax)) begin
      eff_code = 3'(CodeMax);
    end else begin
      eff_code = cfg.clock_div_code;
    end
    for (int i = 0; i < W; i++) begin
      frame_mask[i] = (BcW'(i) < eff_bits);
    end
  end

  assign half    = (PsW + 1)'(1) << eff_code;
  assign full    = half << 1;
  assign ps_inc  = {1'b0, prescale_count} + (PsW + 1)'(1);
  assign top_idx = IdxW'(eff_bits - BcW'(1));

  always_comb begin
    soft_cs_next        = soft_cs;
    rx_hold_full_next   = rx_hold_full;
    tx_hold_full_next   = tx_hold_full;
    tx_hold_next        = tx_hold;
    rx_hold_next        = rx_hold;
    prescale_count_next = prescale_count;
    bit_count_next      = bit_count;
    tx_shift_next       = tx_shift;
    rx_shift_next       = rx_shift;
    clock_level_next    = clock_level;
    shifting_next       = shifting;
    gap_active_next     = gap_active;
    accepted            = 1'b0;
    leading             = 1'b0;

    if (item.cs_write) begin
      soft_cs_next = item.cs_level;
    end
    if (item.rx_read) begin
      rx_hold_full_next = 1'b0;
    end
    if (item.tx_write && !tx_hold_full) begin
      tx_hold_next      = item.tx_data;
      tx_hold_full_next = 1'b1;
      accepted          = 1'b1;
    end

    if (gap_active) begin
      if (ps_inc >= full) begin
        prescale_count_next = '0;
        gap_active_next     = 1'b0;
      end else begin
        prescale_count_next = PsW'(ps_inc);
      end
      clock_level_next = cfg.clock_idle_high;
    end else if (shifting) begin
      if (ps_inc >= half) begin
        prescale_count_next = '0;
        clock_level_next    = !clock_level;
        leading             = (clock_level_next != cfg.clock_idle_high);
        // The data pin changes on one edge of a bit and the input is sampled
        // on the other; which is which depends on the phase setting.
        if ((leading && !cfg.sample_late) || (!leading && cfg.sample_late)) begin
          if (cfg.low_bit_first) begin
            rx_shift_next = ((rx_shift >> 1) | (W'(item.miso_in) << top_idx)) & frame_mask;
          end else begin
            rx_shift_next = ((rx_shift << 1) | W'(item.miso_in)) & frame_mask;
          end
          bit_count_next = bit_count + BcW'(1);
        end else if (!leading || bit_count != '0) begin
          if (cfg.low_bit_first) begin
            tx_shift_next = tx_shift >> 1;
          end else begin
            tx_shift_next = (tx_shift << 1) & frame_mask;
          end
        end
        if (!leading && bit_count_next >= eff_bits) begin
          rx_hold_next      = 16'(rx_shift_next & frame_mask);
          rx_hold_full_next = 1'b1;
          shifting_next     = 1'b0;
          bit_count_next    = '0;
          clock_level_next  = cfg.clock_idle_high;
          if (cfg.gap_pulse_enable && tx_hold_full_next) begin
            gap_active_next = 1'b1;
          end
        end
      end else begin
        prescale_count_next = PsW'(ps_inc);
      end
    end else begin
      clock_level_next = cfg.clock_idle_high;
      // A frame written on this same tick is loaded at once.
      if (tx_hold_full_next) begin
        tx_shift_next       = W'(tx_hold_next) & frame_mask;
        tx_hold_full_next   = 1'b0;
        rx_shift_next       = '0;
        shifting_next       = 1'b1;
        bit_count_next      = '0;
        prescale_count_next = '0;
      end
    end
  end

  assign head = cfg.low_bit_first ? tx_shift_next[0] : tx_shift_next[top_idx];

  always_comb begin
    res.sclk_out    = clock_level_next;
    res.mosi_out    = shifting_next & head;
    res.cs_out      = soft_cs_next | gap_active_next;
    res.tx_empty    = !tx_hold_full_next;
    res.rx_full     = rx_hold_full_next;
    res.rx_data     = rx_hold_next;
    res.busy_res    = shifting_next | tx_hold_full_next | gap_active_next;
    res.tx_accepted = accepted;
  end

  assign status.shifting     = shifting;
  assign status.gap_active   = gap_active;
  assign status.tx_hold_full = tx_hold_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      bit_count      <= '0;
      tx_shift       <= '0;
      rx_shift       <= '0;
      tx_hold        <= '0;
      rx_hold        <= '0;
      tx_hold_full   <= 1'b0;
      rx_hold_full   <= 1'b0;
      clock_level    <= spimc_pkg::ClockIdleHighRst;
      shifting       <= 1'b0;
      gap_active     <= 1'b0;
      soft_cs        <= 1'b1;
    end else if (step) begin
      prescale_count <= prescale_count_next;
      bit_count      <= bit_count_next;
      tx_shift       <= tx_shift_next;
      rx_shift       <= rx_shift_next;
      tx_hold        <= tx_hold_next;
      rx_hold        <= rx_hold_next;
      tx_hold_full   <= tx_hold_full_next;
      rx_hold_full   <= rx_hold_full_next;
      clock_level    <= clock_level_next;
      shifting       <= shifting_next;
      gap_active     <= gap_active_next;
      soft_cs        <= soft_cs_next;
    end
  end

endmodule

FILE: rtl/core/spi_master_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master controller
// Tick-driven SPI master with single-entry transmit and receive buffers.
// ----------------------------------------------------------------------------
// Each input word is one tick of the SPI engine and yields exactly one result
// word carrying the pin levels, buffer flags, receive data and busy state after
// that tick. The block takes one word per clock cycle while the output side takes
// its results: a word is held in the input register, and the engine advances on it
// at the edge that loads its result into the output register.
// While the output side takes every result, words flow back to back; a result
// that waits holds the engine, and once the input register is also full the
// input side stalls. Configuration writes are accepted in every cycle and must
// be issued only while no word is in flight.
module spi_master_controller_top #(
  parameter int MAX_FRAME_BITS = spimc_pkg::MaxFrameBitsDef,
  parameter int MAX_DIV_CODE   = spimc_pkg::MaxDivCodeDef
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tx_write, tx_data[15:0], rx_read, cs_write, cs_level, miso_in, zero fill
  input  logic [spimc_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // sclk_out, mosi_out, cs_out, tx_empty, rx_full, rx_data[15:0], busy_res,
  // tx_accepted, zero fill
  output logic [spimc_pkg::OutTdataW-1:0]  m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spimc_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [spimc_pkg::CfgDataW-1:0]   cfg_data
);

  spimc_pkg::cfg_t        cfg;
  spimc_pkg::item_t       in_item;
  spimc_pkg::res_t        step_res, out_res;
  spimc_pkg::eng_status_t status;

  logic in_valid;
  logic out_valid;
  logic step;

  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;
  assign cfg_ready     = 1'b1;

  spimc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spimc_engine #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS),
    .MAX_DIV_CODE   (MAX_DIV_CODE)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .cfg    (cfg),
    .item   (in_item),
    .res    (step_res),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= spimc_pkg::item_t'(s_axis_tdata[20:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res};

  // An engine tick always leaves a result behind.
  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> m_axis_tvalid)
    else $error("engine tick did not produce a result word");

  // The chip select gap and a running frame never overlap.
  a_gap_excludes_shift: assert property (@(posedge clk) disable iff (rst)
    !(status.shifting && status.gap_active))
    else $error("gap pulse active while a frame shifts");

  // A result that reports idle must also report an empty transmit buffer.
  a_idle_means_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.busy_res) |-> out_res.tx_empty)
    else $error("idle result with transmit buffer full");

  // The gap pulse starts only with a frame waiting behind it.
  a_gap_has_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(status.gap_active) |-> status.tx_hold_full)
    else $error("gap pulse started without a waiting frame");

endmodule
